[rtl/core/rsgf_pkg.sv]
package rsgf_pkg;

  localparam int unsigned RangeW = 16;
  localparam int unsigned CountW = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutDataW = 32;

  localparam logic [RangeW-1:0] RangeMinRst = 16'd450;
  localparam logic [RangeW-1:0] RangeMaxRst = 16'd4000;
  localparam logic [CountW-1:0] ShortLimitRst = 11'd6;
  localparam logic [CountW-1:0] GapSat = 11'd2047;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANGE_MIN   = 2'd0,
    CFG_RANGE_MAX   = 2'd1,
    CFG_SHORT_LIMIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [RangeW-1:0] range_min_mm;
    logic [RangeW-1:0] range_max_mm;
    logic [CountW-1:0] short_run_limit;
  } cfg_t;

  typedef struct packed {
    logic [RangeW-1:0] range_mm;
    logic              is_invalid;
    logic              scan_end;
  } item_t;

  typedef struct packed {
    logic [RangeW-1:0] value_mm;
    logic [CountW-1:0] repeat_count;
    logic              last_of_scan;
  } result_t;

  // value that fills a finished invalid run
  function automatic logic [RangeW-1:0] run_fill(input cfg_t cfg,
                                                 input logic [RangeW-1:0] ref_mm,
                                                 input logic has_ref,
                                                 input logic [CountW-1:0] gap);
    logic signed [RangeW:0] d_max;
    logic signed [RangeW:0] d_min;
    logic [RangeW:0]        a_max;
    logic [RangeW:0]        a_min;
    logic [RangeW-1:0]      fill;
    d_max = $signed({1'b0, cfg.range_max_mm}) - $signed({1'b0, ref_mm});
    d_min = $signed({1'b0, ref_mm}) - $signed({1'b0, cfg.range_min_mm});
    a_max = d_max[RangeW] ? (RangeW+1)'(0) - d_max : d_max;
    a_min = d_min[RangeW] ? (RangeW+1)'(0) - d_min : d_min;
    if (gap < cfg.short_run_limit) begin
      fill = '0;
    end else if (!has_ref) begin
      fill = cfg.range_max_mm;
    end else if (a_max < a_min) begin
      fill = cfg.range_max_mm;
    end else begin
      fill = '0;
    end
    return fill;
  endfunction

endpackage

[rtl/core/rsgf_clean.sv]
module rsgf_clean import rsgf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    fire_i,
  output logic [1:0] nres_o,
  output result_t res0_o,
  output result_t res1_o
);

  logic [CountW-1:0] gap_q, gap_d, gap_inc, fill_gap;
  logic [RangeW-1:0] prev_q, prev_d, clean, fill_ref, fill_val;
  logic              has_prev_q, has_prev_d, fill_has_ref;

  assign gap_inc = (gap_q == GapSat) ? gap_q : gap_q + CountW'(1);

  always_comb begin
    if (item_i.range_mm < cfg_i.range_min_mm) begin
      clean = '0;
    end else if (item_i.range_mm > cfg_i.range_max_mm) begin
      clean = cfg_i.range_max_mm;
    end else begin
      clean = item_i.range_mm;
    end
  end

  // run ending the scan uses the previous sample, otherwise the raw next one
  assign fill_gap     = item_i.is_invalid ? gap_inc : gap_q;
  assign fill_ref     = item_i.is_invalid ? prev_q : item_i.range_mm;
  assign fill_has_ref = item_i.is_invalid ? has_prev_q : 1'b1;
  assign fill_val     = run_fill(cfg_i, fill_ref, fill_has_ref, fill_gap);

  always_comb begin
    nres_o     = 2'd0;
    res0_o     = '{value_mm: fill_val, repeat_count: fill_gap, last_of_scan: 1'b0};
    res1_o     = '{value_mm: clean, repeat_count: CountW'(1),
                   last_of_scan: item_i.scan_end};
    gap_d      = gap_q;
    prev_d     = prev_q;
    has_prev_d = has_prev_q;
    if (item_i.is_invalid) begin
      gap_d = gap_inc;
      if (item_i.scan_end) begin
        nres_o              = 2'd1;
        res0_o.last_of_scan = 1'b1;
      end
    end else begin
      gap_d      = '0;
      prev_d     = clean;
      has_prev_d = 1'b1;
      if (gap_q != '0) begin
        nres_o = 2'd2;
      end else begin
        nres_o = 2'd1;
        res0_o = res1_o;
      end
    end
    if (item_i.scan_end) begin
      gap_d      = '0;
      prev_d     = '0;
      has_prev_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q      <= '0;
      prev_q     <= '0;
      has_prev_q <= 1'b0;
    end else if (fire_i) begin
      gap_q      <= gap_d;
      prev_q     <= prev_d;
      has_prev_q <= has_prev_d;
    end
  end

  a_invalid_no_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.is_invalid |-> nres_o != 2'd2)
    else $error("invalid sample produced two words");

  a_scan_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.scan_end |=> gap_q == '0 && !has_prev_q && prev_q == '0)
    else $error("scan state not cleared at scan end");

endmodule

[rtl/core/rsgf_outq.sv]
module rsgf_outq import rsgf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  result_t    res0_i,
  input  result_t    res1_i,
  output logic [1:0] room_o,
  input  logic       pop_i,
  output logic       valid_o,
  output result_t    head_o
);

  result_t    slot_q [2];
  logic       rd_q, wr_q;
  logic [1:0] count_q;

  assign room_o  = 2'd2 - count_q;
  assign valid_o = count_q != 2'd0;
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      slot_q[wr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      slot_q[~wr_q] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= 1'b0;
      wr_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      wr_q    <= wr_q ^ push_n_i[0];
      count_q <= count_q + push_n_i - {1'b0, pop_i};
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, push_n_i} + {1'b0, count_q}) <= 3'd2)
    else $error("result queue overflow");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd1 && pop_i && push_n_i == 2'd0 |=> !valid_o)
    else $error("result queue did not drain");

endmodule

[rtl/core/range_scan_gap_filter_core.sv]
// channel  | dir | handshake                          | fields (low bit up)
// s_axis   | in  | s_axis_tvalid / s_axis_tready      | tdata: range_mm; tuser: is_invalid;
//          |     |                                    | tlast: scan_end
// m_axis   | out | m_axis_tvalid / m_axis_tready      | tdata: value_mm, repeat_count;
//          |     |                                    | tlast: last_of_scan
// cfg      | in  | cfg_valid_i / cfg_ready_o          | cfg_index_i, cfg_data_i
//
// one sample per cycle while the result queue has room; a valid sample closing
// an invalid run makes two words and moves on only into an empty result queue,
// so it waits while a word is still queued, and the next sample waits while the
// pair drains. a sample passes the input register, then the result queue.
// reset clears scan state and loads the default limits; no clearing pass.
// cfg is always ready; write it only while the core is idle.
module range_scan_gap_filter_core import rsgf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [RangeW-1:0]   s_axis_tdata,  // range_mm
  input  logic                s_axis_tuser,  // is_invalid
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // value_mm, repeat_count, zero pad
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RangeW-1:0]   cfg_data_i
);

  cfg_t       cfg_q;
  item_t      item_q;
  logic       in_valid_q, fire, pop;
  logic [1:0] nres, room, push_n;
  result_t    res0, res1, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{range_min_mm: RangeMinRst, range_max_mm: RangeMaxRst,
                 short_run_limit: ShortLimitRst};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RANGE_MIN:   cfg_q.range_min_mm    <= cfg_data_i;
        CFG_RANGE_MAX:   cfg_q.range_max_mm    <= cfg_data_i;
        CFG_SHORT_LIMIT: cfg_q.short_run_limit <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign fire          = in_valid_q && (nres <= room);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= '{range_mm: s_axis_tdata, is_invalid: s_axis_tuser,
                  scan_end: s_axis_tlast};
    end
  end

  rsgf_clean u_clean (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .fire_i (fire),
    .nres_o (nres),
    .res0_o (res0),
    .res1_o (res1)
  );

  assign push_n = fire ? nres : 2'd0;
  assign pop    = m_axis_tvalid && m_axis_tready;

  rsgf_outq u_outq (
    .clk_i,
    .rst_ni,
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .room_o   (room),
    .pop_i    (pop),
    .valid_o  (m_axis_tvalid),
    .head_o   (head)
  );

  assign m_axis_tdata = {(OutDataW - RangeW - CountW)'(0), head.repeat_count, head.value_mm};
  assign m_axis_tlast = head.last_of_scan;

endmodule
